// ===== design/bfsa_pkg.sv =====
package bfsa_pkg;

  localparam int unsigned MemCells = 65536;
  localparam int unsigned MaxRequests = 1024;
  localparam int unsigned MaxFreeSegments = 1024;

  localparam int unsigned SegIdxW = $clog2(MaxFreeSegments);
  localparam int unsigned ReqIdxW = $clog2(MaxRequests);
  localparam int unsigned CellW = 17;
  localparam int unsigned ReqNumW = 11;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST_RD,
    ST_HIST_WAIT,
    ST_SCAN_RD,
    ST_SCAN,
    ST_COMMIT,
    ST_COMMIT2,
    ST_OUT
  } state_t;

endpackage

// ===== design/bfsa_seg_ram.sv =====
module bfsa_seg_ram
  import bfsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [SegIdxW-1:0]   waddr,
  input  logic [2*CellW:0]     wdata,
  input  logic [SegIdxW-1:0]   raddr,
  output logic [2*CellW:0]     rdata
);

  logic [2*CellW:0] mem [MaxFreeSegments];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/best_fit_segment_allocator_top.sv =====
// Best-fit segment allocator with coalescing.
//
// Input channel (in_valid/in_stall): req_type, alloc_length, freed_request.
// Output channel (out_valid/out_stall): alloc_ok, start_cell, one word per
// allocate request, none per free request.
// cfg_we/cfg_data writes total_size and reinitialises the free list,
// history and request count.
//
// Each request walks the whole free segment table through the single read
// port of the segment RAM, one entry per cycle. One item at a time;
// in_stall stays high while an item is in flight.
//
// After reset, or a configuration write, a clearing pass writes entry 0 as
// one free segment of total_size starting at cell 1 and every other entry
// invalid before the first item is taken. A stalled result word holds in the
// output register; no new item is taken until it has gone.
module best_fit_segment_allocator_top
  import bfsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CellW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [CellW-1:0]   alloc_length,
  input  logic [ReqNumW-1:0] freed_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               alloc_ok,
  output logic [CellW-1:0]   start_cell
);

  localparam int unsigned SumW = CellW + 2;

  state_t state, state_next;

  logic [CellW-1:0]   total_size;
  logic [ReqNumW-1:0] request_number;
  logic [SegIdxW:0]   clr_idx;
  logic [SegIdxW:0]   scan_idx;
  logic [SegIdxW-1:0] rd_idx;

  logic               cur_type;
  logic [CellW-1:0]   cur_len;
  logic [ReqIdxW-1:0] cur_me;
  logic               cur_rec;
  logic [ReqIdxW-1:0] tgt;
  logic               tgt_ok;

  logic [CellW-1:0]   fs;
  logic [CellW-1:0]   fl;
  logic               f_live;

  logic               found, hp, hn, hs;
  logic [SegIdxW-1:0] best, p, n, slot;
  logic [CellW-1:0]   best_s, best_l, p_l, n_l;

  // history entries at or beyond the request count are dead
  logic [2*CellW:0]       hist_mem [MaxRequests];
  logic [2*CellW:0]       hist_rd;

  logic                 seg_we;
  logic [SegIdxW-1:0]   seg_waddr;
  logic [2*CellW:0]     seg_wdata;
  logic [2*CellW:0]     seg_rdata;
  logic                 e_v;
  logic [CellW-1:0]     e_s, e_l;

  bfsa_seg_ram u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(rd_idx), .rdata(seg_rdata)
  );

  assign e_v = seg_rdata[2*CellW];
  assign e_s = seg_rdata[2*CellW-1:CellW];
  assign e_l = seg_rdata[CellW-1:0];
  assign rd_idx = scan_idx[SegIdxW-1:0];

  logic [CellW-1:0] cfg_clamped;
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = CellW'(1);
    end else if ({1'b0, cfg_data} > (CellW+1)'(MemCells)) begin
      cfg_clamped = CellW'(MemCells);
    end
  end

  logic accept_in;
  assign in_stall = (state != ST_IDLE) || out_valid;
  assign accept_in = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (clr_idx == (SegIdxW+1)'(MaxFreeSegments - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (accept_in) state_next = ST_HIST_RD;
      ST_HIST_RD:   state_next = ST_HIST_WAIT;
      ST_HIST_WAIT: state_next = ST_SCAN_RD;
      ST_SCAN_RD:   state_next = ST_SCAN;
      ST_SCAN:      if (scan_idx == (SegIdxW+1)'(MaxFreeSegments)) state_next = ST_COMMIT;
      ST_COMMIT:    state_next = ST_COMMIT2;
      ST_COMMIT2:   state_next = (cur_type == REQ_ALLOC) ? ST_OUT : ST_IDLE;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sums for the neighbour checks in the scan of a free request
  logic [SumW-1:0] e_end, f_end;
  assign e_end = SumW'(e_s) + SumW'(e_l);
  assign f_end = SumW'(fs) + SumW'(fl);

  logic is_alloc;
  assign is_alloc = (cur_type == REQ_ALLOC);

  logic do_free_ok;
  assign do_free_ok = tgt_ok && f_live;

  logic free_done;
  assign free_done = hp || hn || hs;

  // segment RAM writes
  always_comb begin
    seg_we = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        seg_we = 1'b1;
        seg_waddr = clr_idx[SegIdxW-1:0];
        seg_wdata = (clr_idx == '0) ? {1'b1, CellW'(1), total_size} : '0;
      end
      ST_COMMIT: begin
        if (is_alloc) begin
          if (found && cur_len != '0) begin
            seg_we = 1'b1;
            seg_waddr = best;
            seg_wdata = (best_l > cur_len) ?
                        {1'b1, best_s + cur_len, best_l - cur_len} : '0;
          end
        end else if (do_free_ok) begin
          if (hp) begin
            seg_we = 1'b1;
            seg_waddr = p;
            seg_wdata = {1'b1, fs - p_l, p_l + fl + (hn ? n_l : '0)};
          end else if (hn) begin
            seg_we = 1'b1;
            seg_waddr = n;
            seg_wdata = {1'b1, fs, n_l + fl};
          end else if (hs) begin
            seg_we = 1'b1;
            seg_waddr = slot;
            seg_wdata = {1'b1, fs, fl};
          end
        end
      end
      ST_COMMIT2: begin
        if (!is_alloc && do_free_ok && hp && hn) begin
          seg_we = 1'b1;
          seg_waddr = n;
          seg_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept_in) begin
      cur_type <= req_type;
      cur_len <= alloc_length;
      cur_me <= request_number[ReqIdxW-1:0];
      cur_rec <= request_number < ReqNumW'(MaxRequests);
      tgt <= ReqIdxW'(freed_request - ReqNumW'(1));
      tgt_ok <= (freed_request != '0) && (freed_request <= ReqNumW'(MaxRequests)) &&
                (freed_request <= request_number);
    end
    hist_rd <= hist_mem[tgt];
    if (state == ST_HIST_WAIT) begin
      f_live <= hist_rd[2*CellW];
      fs <= hist_rd[2*CellW-1:CellW];
      fl <= hist_rd[CellW-1:0];
    end
    if (state == ST_SCAN_RD) begin
      found <= 1'b0; hp <= 1'b0; hn <= 1'b0; hs <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (is_alloc) begin
        if (e_v && e_l >= cur_len &&
            (!found || e_l < best_l || (e_l == best_l && e_s < best_s))) begin
          found <= 1'b1;
          best <= rd_idx - SegIdxW'(1);
          best_s <= e_s;
          best_l <= e_l;
        end
      end else if (!e_v) begin
        if (!hs) begin
          hs <= 1'b1;
          slot <= rd_idx - SegIdxW'(1);
        end
      end else begin
        if (e_end == SumW'(fs)) begin
          hp <= 1'b1; p <= rd_idx - SegIdxW'(1); p_l <= e_l;
        end
        if (SumW'(e_s) == f_end) begin
          hn <= 1'b1; n <= rd_idx - SegIdxW'(1); n_l <= e_l;
        end
      end
    end
    // own entry written in ST_COMMIT, freed target killed in ST_COMMIT2 after it
    if (state == ST_COMMIT && cur_rec) begin
      hist_mem[cur_me] <= {is_alloc && found && cur_len != '0, best_s, cur_len};
    end else if (state == ST_COMMIT2 && !is_alloc && do_free_ok && free_done) begin
      hist_mem[tgt] <= '0;
    end
    if (state == ST_COMMIT2 && is_alloc) begin
      alloc_ok <= found && cur_len != '0;
      start_cell <= (found && cur_len != '0) ? best_s : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      scan_idx <= '0;
      total_size <= CellW'(MemCells < 65536 ? MemCells : 65536);
      request_number <= '0;
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      total_size <= cfg_clamped;
      request_number <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_SCAN_RD) scan_idx <= (SegIdxW+1)'(1);
      else if (state == ST_SCAN) scan_idx <= scan_idx + 1'b1;
      else scan_idx <= '0;
      if (accept_in && request_number < ReqNumW'(MaxRequests))
        request_number <= request_number + 1'b1;
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== test/tb_best_fit_segment_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_best_fit_segment_allocator_top;
  import bfsa_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CellW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [CellW-1:0]   alloc_length;
  logic [ReqNumW-1:0] freed_request;
  logic               out_valid;
  logic               out_stall;
  logic               alloc_ok;
  logic [CellW-1:0]   start_cell;

  best_fit_segment_allocator_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .alloc_length  (alloc_length),
    .freed_request (freed_request),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alloc_ok      (alloc_ok),
    .start_cell    (start_cell)
  );

  localparam int unsigned ItemLatency = MaxFreeSegments + 80;

  typedef struct packed {
    logic             ok;
    logic [CellW-1:0] start;
  } grant_t;

  typedef struct {
    logic               kind;
    logic [CellW-1:0]   len;
    logic [ReqNumW-1:0] target;
    bit                 typed;
    grant_t             grant;
  } row_t;

  // allocator mirror
  int unsigned pool_size;
  int unsigned fs_start [MaxFreeSegments];
  int unsigned fs_len   [MaxFreeSegments];
  bit          fs_used  [MaxFreeSegments];
  int unsigned blk_start[MaxRequests];
  int unsigned blk_len  [MaxRequests];
  bit          blk_live [MaxRequests];
  int unsigned req_count;

  grant_t grants_due[$];
  int     errors;
  bit     no_idle;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void pool_init(input int unsigned size);
    pool_size = size;
    for (int i = 0; i < MaxFreeSegments; i++) begin
      fs_start[i] = 0;
      fs_len[i] = 0;
      fs_used[i] = 0;
    end
    for (int i = 0; i < MaxRequests; i++) begin
      blk_start[i] = 0;
      blk_len[i] = 0;
      blk_live[i] = 0;
    end
    fs_start[0] = 1;
    fs_len[0] = size;
    fs_used[0] = 1;
    req_count = 0;
  endfunction

  function automatic bit carve(input int unsigned len, output int unsigned where);
    int unsigned best;
    bit found;
    best = 0;
    found = 0;
    where = 0;
    if (len == 0) return 0;
    for (int i = 0; i < MaxFreeSegments; i++) begin
      if (!fs_used[i] || fs_len[i] < len) continue;
      if (!found || fs_len[i] < fs_len[best] ||
          (fs_len[i] == fs_len[best] && fs_start[i] < fs_start[best])) begin
        best = i;
        found = 1;
      end
    end
    if (!found) return 0;
    where = fs_start[best];
    if (fs_len[best] > len) begin
      fs_start[best] += len;
      fs_len[best] -= len;
    end else begin
      fs_used[best] = 0;
    end
    return 1;
  endfunction

  function automatic bit give_back(input int unsigned s, input int unsigned len);
    int unsigned p, n, slot;
    bit hp, hn, hs;
    p = 0; n = 0; slot = 0;
    hp = 0; hn = 0; hs = 0;
    for (int i = 0; i < MaxFreeSegments; i++) begin
      if (!fs_used[i]) begin
        if (!hs) begin
          slot = i;
          hs = 1;
        end
        continue;
      end
      if (fs_start[i] + fs_len[i] == s) begin
        p = i;
        hp = 1;
      end
      if (fs_start[i] == s + len) begin
        n = i;
        hn = 1;
      end
    end
    if (hp && hn) begin
      fs_len[p] += len + fs_len[n];
      fs_used[n] = 0;
    end else if (hp) begin
      fs_len[p] += len;
    end else if (hn) begin
      fs_start[n] = s;
      fs_len[n] += len;
    end else begin
      if (!hs) return 0;
      fs_start[slot] = s;
      fs_len[slot] = len;
      fs_used[slot] = 1;
    end
    return 1;
  endfunction

  // returns 1 when the request yields a result word
  function automatic bit serve(input logic kind, input logic [CellW-1:0] len,
                               input logic [ReqNumW-1:0] target, output grant_t g);
    int unsigned me, where, k;
    bit logged, ok;
    me = req_count;
    logged = me < MaxRequests;
    g = '0;
    if (logged) req_count = me + 1;
    if (kind == REQ_ALLOC) begin
      ok = carve(len, where);
      if (logged) begin
        blk_live[me] = ok;
        blk_start[me] = ok ? where : 0;
        blk_len[me] = ok ? len : 0;
      end
      g.ok = ok;
      g.start = ok ? where[CellW-1:0] : '0;
      return 1;
    end
    if (logged) begin
      blk_live[me] = 0;
      blk_start[me] = 0;
      blk_len[me] = 0;
    end
    if (target >= 1 && target <= MaxRequests) begin
      k = target - 1;
      if (blk_live[k] && give_back(blk_start[k], blk_len[k])) blk_live[k] = 0;
    end
    return 0;
  endfunction

  task automatic send(input logic kind, input logic [CellW-1:0] len,
                      input logic [ReqNumW-1:0] target, input bit typed,
                      input grant_t typed_grant);
    int gap;
    grant_t g;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = kind;
    alloc_length = len;
    freed_request = target;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (serve(kind, len, target, g)) begin
      if (typed && g != typed_grant)
        report($sformatf("mirror disagrees with table: ok %0b start %0d", g.ok, g.start));
      grants_due.push_back(typed ? typed_grant : g);
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    // a trailing free item gives no word; let it finish
    repeat (ItemLatency) @(negedge clk);
  endtask

  task automatic write_size(input logic [CellW-1:0] value);
    int unsigned v;
    v = value;
    if (v < 1) v = 1;
    if (v > MemCells) v = MemCells;
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    pool_init(v);
  endtask

  task automatic random_phase(input int count);
    logic kind;
    logic [CellW-1:0] len;
    logic [ReqNumW-1:0] target;
    int unsigned r, cap, k;
    cap = pool_size < 40 ? pool_size : 40;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      kind = (r < 40) ? REQ_FREE : REQ_ALLOC;
      len = CellW'($urandom_range(1, cap));
      target = ReqNumW'($urandom_range(0, 2047));
      if (kind == REQ_ALLOC) begin
        r = $urandom_range(0, 99);
        if (r < 8) len = CellW'($urandom_range(1, pool_size));
        else if (r < 12) len = '0;
        else if (r < 17) len = CellW'($urandom);
        else if (r < 20) len = CellW'(MemCells);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85 && req_count > 0) begin
          // aim mostly at live blocks
          k = $urandom_range(0, req_count - 1);
          for (int t = 0; t < 4 && !blk_live[k]; t++) k = $urandom_range(0, req_count - 1);
          target = ReqNumW'(k + 1);
        end else if (r < 90) begin
          target = '0;
        end else if (r < 93) begin
          target = '1;
        end
      end
      send(kind, len, target, 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    int gap;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      gap = no_idle ? 0 : $urandom_range(0, 13);
      out_stall = gap > 0;
      repeat (gap) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (grants_due.size() == 0) begin
        report($sformatf("unexpected word ok %0b start %0d", alloc_ok, start_cell));
      end else begin
        grant_t g;
        g = grants_due.pop_front();
        if (alloc_ok !== g.ok)
          report($sformatf("alloc_ok %0b, wanted %0b", alloc_ok, g.ok));
        if (start_cell !== g.start)
          report($sformatf("start_cell %0d, wanted %0d", start_cell, g.start));
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL best_fit_segment_allocator_top");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [CellW-1:0] sizes[$];
    errors = 0;
    no_idle = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_ALLOC;
    alloc_length = '0;
    freed_request = '0;
    pool_init(MemCells);
    repeat (9) @(negedge clk);
    rst = 1'b0;

    rows = '{
      '{REQ_ALLOC, 17'd1,      11'd0,    1, '{1'b1, 17'd1}},
      '{REQ_ALLOC, 17'd65535,  11'd0,    1, '{1'b1, 17'd2}},
      '{REQ_ALLOC, 17'd1,      11'd0,    1, '{1'b0, 17'd0}},  // pool full
      '{REQ_ALLOC, 17'd0,      11'd0,    1, '{1'b0, 17'd0}},  // zero length
      '{REQ_FREE,  17'd0,      11'd1,    0, '{1'b0, 17'd0}},
      '{REQ_ALLOC, 17'd1,      11'd0,    1, '{1'b1, 17'd1}},
      '{REQ_FREE,  17'd0,      11'd0,    0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd2047, 0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd1000, 0, '{1'b0, 17'd0}},  // not yet issued
      '{REQ_FREE,  17'd0,      11'd5,    0, '{1'b0, 17'd0}},  // names a free item
      '{REQ_FREE,  17'd0,      11'd3,    0, '{1'b0, 17'd0}},  // failed alloc
      '{REQ_FREE,  17'd0,      11'd2,    0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd2,    0, '{1'b0, 17'd0}},  // double free
      '{REQ_ALLOC, 17'h1ffff,  11'd0,    1, '{1'b0, 17'd0}},
      '{REQ_ALLOC, 17'd65535,  11'd0,    1, '{1'b1, 17'd2}},
      '{REQ_FREE,  17'd0,      11'd15,   0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd6,    0, '{1'b0, 17'd0}},
      '{REQ_ALLOC, 17'd65536,  11'd0,    1, '{1'b1, 17'd1}},
      '{REQ_FREE,  17'd0,      11'd18,   0, '{1'b0, 17'd0}},
      '{REQ_ALLOC, 17'd10,     11'd0,    1, '{1'b1, 17'd1}},
      '{REQ_ALLOC, 17'd10,     11'd0,    1, '{1'b1, 17'd11}},
      '{REQ_ALLOC, 17'd10,     11'd0,    1, '{1'b1, 17'd21}},
      '{REQ_FREE,  17'd0,      11'd20,   0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd22,   0, '{1'b0, 17'd0}},
      '{REQ_FREE,  17'd0,      11'd21,   0, '{1'b0, 17'd0}},  // merges both sides
      '{REQ_ALLOC, 17'd65536,  11'd0,    1, '{1'b1, 17'd1}}
    };
    foreach (rows[i])
      send(rows[i].kind, rows[i].len, rows[i].target, rows[i].typed, rows[i].grant);
    random_phase(60);
    drain();

    sizes = '{17'd0, 17'd64, 17'h1ffff, 17'd300, 17'd1, 17'd5000, 17'd65536, 17'd20};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      no_idle = (i % 3 == 2);
      random_phase(65);
      drain();
    end

    if (errors == 0) begin
      $display("PASS best_fit_segment_allocator_top");
    end else begin
      $display("FAIL best_fit_segment_allocator_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bfsa_pkg.sv
design/bfsa_seg_ram.sv
design/best_fit_segment_allocator_top.sv
test/tb_best_fit_segment_allocator_top.sv
